### hw/rtl/lfbd_pkg.sv
// Shared constants and types for the LZSS flag-byte decoder.
// No dependencies; lfbd_hist and the top module import this package, lfbd_if does not.
`timescale 1ns / 1ps
`default_nettype none

package lfbd_pkg;

  localparam int unsigned WIN_DEPTH   = 4096;
  localparam int unsigned WIN_AW      = $clog2(WIN_DEPTH);
  localparam int unsigned CNT_W       = 24;
  localparam int unsigned POS_W       = 24;
  localparam int unsigned DIST_W      = 12;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned TIDX_W      = 4;
  localparam int unsigned FLAG_TOKENS = 8;
  localparam int unsigned LEN_BIAS    = 3;
  localparam int unsigned LEN_MAX     = 15 + LEN_BIAS;

  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
    logic [7:0]        data;
  } hist_wr_t;

  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
  } hist_rd_t;

endpackage

`default_nettype wire

### hw/rtl/lfbd_if.sv
// Stream interfaces of the decoder: compressed input beats and decoded result beats.
// Valid/ready handshake; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface lfbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_in;
  logic       last_in;

  modport source (output valid, output in_byte, output first_in, output last_in,
                  input ready);
  modport sink (input valid, input in_byte, input first_in, input last_in,
                output ready);
endinterface

interface lfbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_data;
  logic        last_of_run;
  logic        done_res;
  logic [23:0] total_count;

  modport source (output valid, output out_byte, output is_data, output last_of_run,
                  output done_res, output total_count, input ready);
  modport sink (input valid, input out_byte, input is_data, input last_of_run,
                input done_res, input total_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/lfbd_hist.sv
// History window: one-write, one-read synchronous memory with a registered read.
// Forwards a byte written in the same cycle as a read of that entry. Uses lfbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfbd_hist
  import lfbd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire hist_wr_t wr_i,
  input  wire hist_rd_t rd_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [WIN_DEPTH];
  logic [7:0] rdata_q;
  logic [7:0] fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q    <= mem[rd_i.addr];
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_i.en) begin
      fwd_q <= wr_i.en && (wr_i.addr == rd_i.addr);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

`default_nettype wire

### hw/rtl/lzss_flag_byte_decoder_top.sv
// LZSS flag-byte decoder: flag byte, literals and 12-bit distance / 4-bit length references.
// A literal at a position below max_q is loaded into the output register when accepted; a
// reference copies up to 18 bytes via the history read port, one byte per cycle while the
// output is free, or none when no byte can be copied, and a zero distance starts no copy.
// The end-of-block report is its own output beat. Output backpressure stalls all work.
// Reset is asynchronous, active low; history needs no clearing pass, since only entries
// written in the current block are ever read.
`timescale 1ns / 1ps
`default_nettype none

module lzss_flag_byte_decoder_top
  import lfbd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  lfbd_in_if.sink                in_i,
  lfbd_out_if.source             out_o,
  input  wire logic              cfg_we_i,
  input  wire logic [POS_W-1:0]  cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_COPY   = 3'b010,
    S_REPORT = 3'b100
  } lfbd_state_e;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [LEN_W-1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(n);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  lfbd_state_e       state_q, state_d;
  logic [POS_W-1:0]  wp_q, wp_d, max_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        flag_q, flag_d, low_q, low_d;
  logic [TIDX_W-1:0] tidx_q, tidx_d;
  logic              phase_q, phase_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic              lastp_q, lastp_d;

  logic              ovalid_q, ovalid_d;
  logic [7:0]        obyte_q, obyte_d;
  logic              odata_q, odata_d, olast_q, olast_d, odone_q, odone_d;
  logic [CNT_W-1:0]  ocnt_q, ocnt_d;
  logic              out_load;

  logic              slot_free, in_acc;
  logic [POS_W-1:0]  wp_e;
  logic [CNT_W-1:0]  cnt_e;
  logic [7:0]        flag_e, low_e;
  logic [TIDX_W-1:0] tidx_e;
  logic              phase_e;
  logic [15:0]       word;
  logic [DIST_W-1:0] dist_w;
  logic [LEN_W-1:0]  len_w;
  logic [POS_W:0]    wp_inc;
  logic              cur_stop, next_stop;

  hist_wr_t   hwr;
  hist_rd_t   hrd;
  logic [7:0] hdata;

  lfbd_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (hwr),
    .rd_i    (hrd),
    .rdata_o (hdata)
  );

  assign slot_free  = !ovalid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && slot_free;
  assign in_acc     = in_i.valid && in_i.ready;

  assign wp_e    = in_i.first_in ? '0 : wp_q;
  assign cnt_e   = in_i.first_in ? '0 : cnt_q;
  assign flag_e  = in_i.first_in ? '0 : flag_q;
  assign low_e   = in_i.first_in ? '0 : low_q;
  assign phase_e = in_i.first_in ? 1'b0 : phase_q;
  assign tidx_e  = in_i.first_in ? TIDX_W'(FLAG_TOKENS) : tidx_q;

  assign word   = {in_i.in_byte, low_e};
  assign dist_w = word[15:4];
  assign len_w  = {1'b0, word[3:0]} + LEN_W'(LEN_BIAS);

  assign wp_inc    = {1'b0, wp_q} + (POS_W+1)'(1);
  assign cur_stop  = (rem_q == '0) || (wp_q >= max_q) || (POS_W'(dist_q) > wp_q);
  assign next_stop = (rem_q == LEN_W'(1)) || (wp_inc >= {1'b0, max_q});

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    cnt_d    = cnt_q;
    flag_d   = flag_q;
    low_d    = low_q;
    tidx_d   = tidx_q;
    phase_d  = phase_q;
    dist_d   = dist_q;
    rem_d    = rem_q;
    lastp_d  = lastp_q;
    out_load = 1'b0;
    obyte_d  = obyte_q;
    odata_d  = odata_q;
    olast_d  = olast_q;
    odone_d  = odone_q;
    ocnt_d   = ocnt_q;
    hwr      = '{en: 1'b0, addr: wp_q[WIN_AW-1:0], data: in_i.in_byte};
    hrd      = '{en: 1'b0, addr: wp_q[WIN_AW-1:0] - WIN_AW'(dist_q)};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          wp_d    = wp_e;
          cnt_d   = cnt_e;
          flag_d  = flag_e;
          low_d   = low_e;
          tidx_d  = tidx_e;
          phase_d = phase_e;
          lastp_d = in_i.last_in;
          if (tidx_e[TIDX_W-1]) begin
            flag_d = in_i.in_byte;
            tidx_d = '0;
          end else if (!flag_e[tidx_e[TIDX_W-2:0]]) begin
            cnt_d  = sat_add(cnt_e, LEN_W'(1));
            tidx_d = tidx_e + TIDX_W'(1);
            if (wp_e < max_q) begin
              hwr      = '{en: 1'b1, addr: wp_e[WIN_AW-1:0], data: in_i.in_byte};
              wp_d     = wp_e + POS_W'(1);
              out_load = 1'b1;
              obyte_d  = in_i.in_byte;
              odata_d  = 1'b1;
              olast_d  = !in_i.last_in;
              odone_d  = 1'b0;
              ocnt_d   = sat_add(cnt_e, LEN_W'(1));
            end
          end else if (!phase_e) begin
            low_d   = in_i.in_byte;
            phase_d = 1'b1;
          end else begin
            phase_d = 1'b0;
            tidx_d  = tidx_e + TIDX_W'(1);
            cnt_d   = sat_add(cnt_e, len_w);
            if (dist_w != '0) begin
              dist_d  = dist_w;
              rem_d   = len_w;
              hrd     = '{en: 1'b1, addr: wp_e[WIN_AW-1:0] - WIN_AW'(dist_w)};
              state_d = S_COPY;
            end
          end
          if (in_i.last_in && (state_d == S_IDLE)) begin
            state_d = S_REPORT;
          end
        end
      end
      S_COPY: begin
        if (cur_stop) begin
          state_d = lastp_q ? S_REPORT : S_IDLE;
        end else if (slot_free) begin
          hwr      = '{en: 1'b1, addr: wp_q[WIN_AW-1:0], data: hdata};
          hrd      = '{en: 1'b1, addr: wp_inc[WIN_AW-1:0] - WIN_AW'(dist_q)};
          wp_d     = wp_inc[POS_W-1:0];
          rem_d    = rem_q - LEN_W'(1);
          out_load = 1'b1;
          obyte_d  = hdata;
          odata_d  = 1'b1;
          olast_d  = next_stop && !lastp_q;
          odone_d  = 1'b0;
          ocnt_d   = cnt_q;
          if (next_stop) begin
            state_d = lastp_q ? S_REPORT : S_IDLE;
          end
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          out_load = 1'b1;
          obyte_d  = '0;
          odata_d  = 1'b0;
          olast_d  = 1'b1;
          odone_d  = 1'b1;
          ocnt_d   = cnt_q;
          wp_d     = '0;
          cnt_d    = '0;
          flag_d   = '0;
          low_d    = '0;
          phase_d  = 1'b0;
          tidx_d   = TIDX_W'(FLAG_TOKENS);
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ovalid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wp_q     <= '0;
      cnt_q    <= '0;
      flag_q   <= '0;
      low_q    <= '0;
      tidx_q   <= TIDX_W'(FLAG_TOKENS);
      phase_q  <= 1'b0;
      dist_q   <= '0;
      rem_q    <= '0;
      lastp_q  <= 1'b0;
      ovalid_q <= 1'b0;
      max_q    <= {POS_W{1'b1}};
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      cnt_q    <= cnt_d;
      flag_q   <= flag_d;
      low_q    <= low_d;
      tidx_q   <= tidx_d;
      phase_q  <= phase_d;
      dist_q   <= dist_d;
      rem_q    <= rem_d;
      lastp_q  <= lastp_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
    odone_q <= odone_d;
    ocnt_q  <= ocnt_d;
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_byte    = obyte_q;
  assign out_o.is_data     = odata_q;
  assign out_o.last_of_run = olast_q;
  assign out_o.done_res    = odone_q;
  assign out_o.total_count = ocnt_q;

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready)
    else $error("input beat taken while a token is still in progress");

  a_copy_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> (dist_q != '0) && (rem_q <= LEN_W'(LEN_MAX)))
    else $error("copy running with zero distance or oversized length");

  a_write_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwr.en |-> (out_load && (wp_d == wp_q + POS_W'(1))) || (in_acc && in_i.first_in))
    else $error("history write without an emitted byte");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("output register overwritten while holding a beat");

endmodule

`default_nettype wire
